/* design/xmb_pkg.sv */
// ----------------------------------------------------------------------------
// xmb_pkg
// Shared types and constants for the XMODEM block receiver.
// ----------------------------------------------------------------------------
package xmb_pkg;

  localparam int PAYLOAD_BYTES_DEF = 128;
  localparam int RD_IDX_W          = 7;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_CAN = 8'h18;

  typedef enum logic [3:0] {
    ST_SOH        = 4'd0,
    ST_BLOCK_OK   = 4'd1,
    ST_DUP        = 4'd2,
    ST_WRONG      = 4'd3,
    ST_COMPL_OK   = 4'd4,
    ST_DATA       = 4'd5,
    ST_DATA_DONE  = 4'd6,
    ST_BLOCK_DONE = 4'd7,
    ST_CHK_FAIL   = 4'd8,
    ST_DISCARD    = 4'd9,
    ST_EOT        = 4'd10,
    ST_CANCEL     = 4'd11,
    ST_IGNORED    = 4'd12,
    ST_READBACK   = 4'd13
  } status_t;

  // Write and clear request from the protocol controller to the payload store.
  typedef struct packed {
    logic                wr_en;
    logic [RD_IDX_W-1:0] wr_addr;
    logic [7:0]          wr_data;
    logic                clr;
  } ram_wr_t;

endpackage

/* design/xmb_payload_ram.sv */
// ----------------------------------------------------------------------------
// xmb_payload_ram
// Payload store: one synchronous RAM with registered read data, plus one
// written flag per entry that a cancel clears at once.
// ----------------------------------------------------------------------------
module xmb_payload_ram #(
  parameter int PAYLOAD_BYTES = xmb_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic                         rd_en,
  input  logic [xmb_pkg::RD_IDX_W-1:0] rd_addr,
  input  xmb_pkg::ram_wr_t             wr,
  output logic [7:0]                   rd_data
);

  // Only the positions a readback can address need storage.
  localparam int STORE_DEPTH = (PAYLOAD_BYTES < (1 << xmb_pkg::RD_IDX_W)) ?
                               PAYLOAD_BYTES : (1 << xmb_pkg::RD_IDX_W);
  localparam int AW = $clog2(STORE_DEPTH);

  logic [7:0]             mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_r;
  logic [7:0]             rd_q_r;
  logic                   rd_hit_r;
  logic                   rd_in_range;

  assign rd_in_range = (32'(rd_addr) < 32'(PAYLOAD_BYTES));

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      mem[wr.wr_addr[AW-1:0]] <= wr.wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr.clr) begin
        valid_r <= '0;
      end else if (wr.wr_en) begin
        valid_r[wr.wr_addr[AW-1:0]] <= 1'b1;
      end
      // The hit flag follows every transfer so that a non-readback result
      // reads as zero.
      if (advance) begin
        rd_hit_r <= rd_en && rd_in_range && valid_r[rd_addr[AW-1:0]];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_q_r : 8'd0;

endmodule

/* design/xmb_ctrl.sv */
// ----------------------------------------------------------------------------
// xmb_ctrl
// Packet framing controller: tracks the packet phase, checks the block
// number, complement and checksum, and issues payload writes.
// ----------------------------------------------------------------------------
module xmb_ctrl #(
  parameter int PAYLOAD_BYTES = xmb_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rx_go,
  input  logic [7:0]       rx_byte,
  output xmb_pkg::ram_wr_t wr,
  output xmb_pkg::status_t rx_status,
  output logic [7:0]       last_block_nxt
);

  localparam int POS_W       = $clog2(PAYLOAD_BYTES);
  localparam int LAST_POS    = PAYLOAD_BYTES - 1;
  localparam int STORE_DEPTH = (PAYLOAD_BYTES < (1 << xmb_pkg::RD_IDX_W)) ?
                               PAYLOAD_BYTES : (1 << xmb_pkg::RD_IDX_W);

  typedef enum logic [4:0] {
    PH_WAIT   = 5'b00001,
    PH_BLOCK  = 5'b00010,
    PH_NBLOCK = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_CHKSUM = 5'b10000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       last_r, last_nxt;
  logic [7:0]       exp_r, exp_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             disc_r, disc_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic             store_en;
  logic             clr;
  xmb_pkg::status_t st;

  // Positions beyond the readable range are counted but never stored.
  assign store_en = ({1'b0, pos_r} < (POS_W + 1)'(STORE_DEPTH));

  always_comb begin
    phase_nxt = phase_r;
    last_nxt  = last_r;
    exp_nxt   = exp_r;
    pos_nxt   = pos_r;
    disc_nxt  = disc_r;
    sum_nxt   = sum_r;
    clr       = 1'b0;
    st        = xmb_pkg::ST_IGNORED;
    wr        = '0;
    if (rx_byte == xmb_pkg::CH_CAN) begin
      clr = 1'b1;
      st  = xmb_pkg::ST_CANCEL;
    end else begin
      unique case (phase_r)
        PH_WAIT: begin
          if (rx_byte == xmb_pkg::CH_EOT) begin
            st = xmb_pkg::ST_EOT;
          end else if (rx_byte == xmb_pkg::CH_SOH) begin
            phase_nxt = PH_BLOCK;
            st        = xmb_pkg::ST_SOH;
          end else begin
            st = xmb_pkg::ST_IGNORED;
          end
        end
        PH_BLOCK: begin
          phase_nxt = PH_NBLOCK;
          if (rx_byte == last_r) begin
            disc_nxt = 1'b1;
            st       = xmb_pkg::ST_DUP;
          end else if (rx_byte == last_r + 8'd1) begin
            exp_nxt = ~rx_byte;
            st      = xmb_pkg::ST_BLOCK_OK;
          end else begin
            disc_nxt = 1'b1;
            st       = xmb_pkg::ST_WRONG;
          end
        end
        PH_NBLOCK: begin
          phase_nxt = PH_DATA;
          pos_nxt   = '0;
          sum_nxt   = 8'd0;
          if (disc_r) begin
            st = xmb_pkg::ST_DISCARD;
          end else if (rx_byte != exp_r) begin
            disc_nxt = 1'b1;
            st       = xmb_pkg::ST_WRONG;
          end else begin
            st = xmb_pkg::ST_COMPL_OK;
          end
        end
        PH_DATA: begin
          if (!disc_r) begin
            wr.wr_en   = rx_go && store_en;
            wr.wr_addr = xmb_pkg::RD_IDX_W'(pos_r);
            wr.wr_data = rx_byte;
            sum_nxt    = sum_r + rx_byte;
          end
          if (pos_r == POS_W'(LAST_POS)) begin
            phase_nxt = PH_CHKSUM;
            st        = disc_r ? xmb_pkg::ST_DISCARD : xmb_pkg::ST_DATA_DONE;
          end else begin
            pos_nxt = pos_r + 1'b1;
            st      = disc_r ? xmb_pkg::ST_DISCARD : xmb_pkg::ST_DATA;
          end
        end
        PH_CHKSUM: begin
          phase_nxt = PH_WAIT;
          if (disc_r) begin
            disc_nxt = 1'b0;
            st       = xmb_pkg::ST_DISCARD;
          end else if (sum_r == rx_byte) begin
            last_nxt = last_r + 8'd1;
            st       = xmb_pkg::ST_BLOCK_DONE;
          end else begin
            st = xmb_pkg::ST_CHK_FAIL;
          end
        end
        default: begin
          clr = 1'b1;
          st  = xmb_pkg::ST_CANCEL;
        end
      endcase
    end
    if (clr) begin
      phase_nxt = PH_WAIT;
      last_nxt  = 8'd0;
      exp_nxt   = 8'd0;
      pos_nxt   = '0;
      disc_nxt  = 1'b0;
      sum_nxt   = 8'd0;
    end
    wr.clr = rx_go && clr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      last_r  <= 8'd0;
      exp_r   <= 8'd0;
      pos_r   <= '0;
      disc_r  <= 1'b0;
      sum_r   <= 8'd0;
    end else if (rx_go) begin
      phase_r <= phase_nxt;
      last_r  <= last_nxt;
      exp_r   <= exp_nxt;
      pos_r   <= pos_nxt;
      disc_r  <= disc_nxt;
      sum_r   <= sum_nxt;
    end
  end

  assign rx_status      = st;
  assign last_block_nxt = rx_go ? last_nxt : last_r;

endmodule

/* design/xmodem_block_receiver.sv */
// Results are registered and presented in the cycle after the input transfer.
// Throughput: one item per cycle while the result side is ready; the payload
// RAM has one write and one read port, with the read data registered in it.
// Reset: synchronous, active low; it clears the framing state and the
// per-entry written flags at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// xmodem_block_receiver
// XMODEM checksum-mode receiver taking one serial byte or one payload
// readback request per transfer and returning one status result each.
// ----------------------------------------------------------------------------
module xmodem_block_receiver #(
  parameter int PAYLOAD_BYTES = xmb_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] rx_byte, [14:8] read_index, [15] zero
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [3:0] status, [11:4] read_data,
                                  // [19:12] last_good_block, [23:20] zero
);

  logic                         accept;
  logic                         rx_go;
  logic                         rd_go;
  xmb_pkg::ram_wr_t             wr;
  xmb_pkg::status_t             rx_status;
  logic [7:0]                   last_block_nxt;
  logic [7:0]                   rd_data;
  logic                         out_valid_r;
  xmb_pkg::status_t             status_r;
  logic [7:0]                   last_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign rx_go     = accept && !in_tuser;
  assign rd_go     = accept && in_tuser;

  xmb_ctrl #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_go         (rx_go),
    .rx_byte       (in_tdata[7:0]),
    .wr            (wr),
    .rx_status     (rx_status),
    .last_block_nxt(last_block_nxt)
  );

  xmb_payload_ram #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(accept),
    .rd_en  (rd_go),
    .rd_addr(in_tdata[14:8]),
    .wr     (wr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= in_tuser ? xmb_pkg::ST_READBACK : rx_status;
      last_r   <= last_block_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, last_r, rd_data, status_r};

`ifndef SYNTHESIS
  a_zero_unless_readback: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status_r != xmb_pkg::ST_READBACK) |-> rd_data == 8'd0)
    else $error("read data not zero on a non-readback result");

  a_cancel_result: assert property (@(posedge clk) disable iff (!rst_n)
    rx_go && (in_tdata[7:0] == xmb_pkg::CH_CAN) |=>
      out_tvalid && (status_r == xmb_pkg::ST_CANCEL) && (last_r == 8'd0))
    else $error("cancel did not report cancel with the block count cleared");

  a_write_only_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.wr_en || wr.clr) |-> rx_go && !in_tuser)
    else $error("payload store changed outside a serial byte transfer");

  a_readback_status: assert property (@(posedge clk) disable iff (!rst_n)
    rd_go |=> out_tvalid && (status_r == xmb_pkg::ST_READBACK))
    else $error("readback transfer did not report readback");

  a_block_done_advance: assert property (@(posedge clk) disable iff (!rst_n)
    rx_go && (rx_status == xmb_pkg::ST_BLOCK_DONE) |=>
      last_r == $past(u_ctrl.last_r) + 8'd1)
    else $error("completed block did not advance the last good block");
`endif

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the XMODEM checksum-mode block receiver.
// A stimulus table drives the framing corner cases first. Random packets
// follow: good, repeated, out of sequence, bad complement, bad checksum and
// aborted, with random readbacks mixed in. A bench model of the framing
// state predicts results the table leaves open. Both sides of the stream
// stall at random, and the result side is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAYLOAD     = xmb_pkg::PAYLOAD_BYTES_DEF;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 120;
  localparam int CALM_ITEMS  = 60;

  typedef struct packed {
    logic       readback;
    logic [7:0] rx_byte;
    logic [6:0] index;
  } xfer_t;

  typedef struct packed {
    xmb_pkg::status_t status;
    logic [7:0]       read_data;
    logic [7:0]       last_good;
  } report_t;

  typedef struct {
    logic             readback;
    logic [7:0]       rx;
    logic [6:0]       idx;
    int               reps;
    logic             fixed;
    xmb_pkg::status_t st;
    logic [7:0]       rd;
    logic [7:0]       lgb;
  } row_t;

  typedef enum logic [4:0] {
    SEEK_SOH  = 5'b00001,
    GET_BLOCK = 5'b00010,
    GET_COMPL = 5'b00100,
    GET_DATA  = 5'b01000,
    GET_SUM   = 5'b10000
  } frame_phase_t;

  typedef enum int {
    PK_GOOD, PK_REPEAT, PK_OUT_OF_SEQ, PK_BAD_COMPL, PK_BAD_SUM, PK_ABORT
  } pkt_kind_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] rx_byte, [14:8] read_index, [15] zero
  logic        in_tuser;   // [0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [3:0] status, [11:4] read_data, [19:12] last_good_block

  // Framing state of the bench's own receiver model.
  frame_phase_t fr_phase;
  logic [7:0]   blk_good;
  logic [7:0]   want_compl;
  logic [7:0]   left;
  logic         dropping;
  logic [7:0]   csum;
  logic [7:0]   payload [0:PAYLOAD-1];
  logic         written [0:PAYLOAD-1];

  report_t status_due [$];
  xfer_t   cur_item;
  bit      cur_fixed;
  report_t cur_want;
  int      items_sent = 0;
  int      mismatches = 0;
  int      quiet      = 0;
  bit      calm       = 1'b0;
  bit      hold_ask   = 1'b0;

  xmodem_block_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_rx_model();
    fr_phase   = SEEK_SOH;
    blk_good   = 8'h00;
    want_compl = 8'h00;
    left       = 8'(PAYLOAD);
    dropping   = 1'b0;
    csum       = 8'h00;
    for (int i = 0; i < PAYLOAD; i++) begin
      payload[i] = 8'h00;
      written[i] = 1'b0;
    end
  endfunction

  function automatic report_t xmodem_rx_step(xfer_t it);
    report_t    r;
    logic [7:0] b;
    logic [6:0] pos;
    b           = it.rx_byte;
    r.read_data = 8'h00;
    r.status    = xmb_pkg::ST_READBACK;
    if (it.readback) begin
      if (written[it.index]) r.read_data = payload[it.index];
    end else if (b == xmb_pkg::CH_CAN) begin
      clear_rx_model();
      r.status = xmb_pkg::ST_CANCEL;
    end else begin
      case (fr_phase)
        SEEK_SOH: begin
          if (b == xmb_pkg::CH_EOT) begin
            r.status = xmb_pkg::ST_EOT;
          end else if (b == xmb_pkg::CH_SOH) begin
            fr_phase = GET_BLOCK;
            r.status = xmb_pkg::ST_SOH;
          end else begin
            r.status = xmb_pkg::ST_IGNORED;
          end
        end
        GET_BLOCK: begin
          fr_phase = GET_COMPL;
          if (b == blk_good) begin
            dropping = 1'b1;
            r.status = xmb_pkg::ST_DUP;
          end else if (b == blk_good + 8'd1) begin
            want_compl = ~b;
            r.status   = xmb_pkg::ST_BLOCK_OK;
          end else begin
            dropping = 1'b1;
            r.status = xmb_pkg::ST_WRONG;
          end
        end
        GET_COMPL: begin
          fr_phase = GET_DATA;
          left     = 8'(PAYLOAD);
          csum     = 8'h00;
          if (dropping) begin
            r.status = xmb_pkg::ST_DISCARD;
          end else if (b != want_compl) begin
            dropping = 1'b1;
            r.status = xmb_pkg::ST_WRONG;
          end else begin
            r.status = xmb_pkg::ST_COMPL_OK;
          end
        end
        GET_DATA: begin
          if (left == 8'd0 || left > PAYLOAD) left = 8'(PAYLOAD);
          if (!dropping) begin
            pos          = 7'(PAYLOAD - left);
            payload[pos] = b;
            written[pos] = 1'b1;
            csum         = csum + b;
          end
          left = left - 8'd1;
          if (left == 8'd0) begin
            fr_phase = GET_SUM;
            r.status = dropping ? xmb_pkg::ST_DISCARD : xmb_pkg::ST_DATA_DONE;
          end else begin
            r.status = dropping ? xmb_pkg::ST_DISCARD : xmb_pkg::ST_DATA;
          end
        end
        GET_SUM: begin
          fr_phase = SEEK_SOH;
          if (dropping) begin
            dropping = 1'b0;
            r.status = xmb_pkg::ST_DISCARD;
          end else if (csum == b) begin
            blk_good = blk_good + 8'd1;
            r.status = xmb_pkg::ST_BLOCK_DONE;
          end else begin
            r.status = xmb_pkg::ST_CHK_FAIL;
          end
        end
        default: begin
          clear_rx_model();
          r.status = xmb_pkg::ST_CANCEL;
        end
      endcase
    end
    r.last_good = blk_good;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(xfer_t it, bit fixed = 1'b0, report_t want = '0);
    while (!calm && $urandom_range(0, 99) < 16) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    cur_item   = it;
    cur_fixed  = fixed;
    cur_want   = want;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, it.index, it.rx_byte};
    in_tuser  <= it.readback;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_readback(logic [6:0] idx);
    xfer_t it;
    it = '{1'b1, 8'($urandom_range(0, 255)), idx};
    send_item(it);
  endtask

  // A serial byte, now and then preceded by a readback of a random entry.
  task automatic send_serial(logic [7:0] b);
    xfer_t it;
    if ($urandom_range(0, 99) < 6) send_readback(7'($urandom_range(0, 127)));
    it = '{1'b0, b, 7'($urandom_range(0, 127))};
    send_item(it);
  endtask

  task automatic send_packet(pkt_kind_t kind);
    logic [7:0] frame [0:PAYLOAD+3];
    logic [7:0] blk;
    logic [7:0] sum;
    int         cut;
    blk = blk_good + 8'd1;
    if (kind == PK_REPEAT) begin
      blk = blk_good;
    end else if (kind == PK_OUT_OF_SEQ) begin
      do begin
        blk = 8'($urandom_range(0, 255));
      end while (blk == blk_good || blk == blk_good + 8'd1 || blk == xmb_pkg::CH_CAN ||
                 ~blk == xmb_pkg::CH_CAN);
    end
    // Payload bytes never carry a cancel, nor may the checksum become one.
    do begin
      sum = 8'h00;
      for (int i = 0; i < PAYLOAD; i++) begin
        frame[3+i] = 8'($urandom_range(0, 255));
        if (frame[3+i] == xmb_pkg::CH_CAN) frame[3+i] = ~xmb_pkg::CH_CAN;
        sum = sum + frame[3+i];
      end
    end while (sum == xmb_pkg::CH_CAN);
    frame[0]         = xmb_pkg::CH_SOH;
    frame[1]         = blk;
    frame[2]         = ~blk;
    frame[PAYLOAD+3] = sum;
    if (kind == PK_BAD_COMPL) begin
      do begin
        frame[2] = 8'($urandom_range(0, 255));
      end while (frame[2] == ~blk || frame[2] == xmb_pkg::CH_CAN);
    end else if (kind == PK_BAD_SUM) begin
      do begin
        frame[PAYLOAD+3] = 8'($urandom_range(0, 255));
      end while (frame[PAYLOAD+3] == sum || frame[PAYLOAD+3] == xmb_pkg::CH_CAN);
    end
    cut = (kind == PK_ABORT) ? $urandom_range(1, PAYLOAD + 3) : PAYLOAD + 4;
    for (int i = 0; i < cut; i++) send_serial(frame[i]);
    if (kind == PK_ABORT) send_serial(xmb_pkg::CH_CAN);
  endtask

  // Result side: random stalls, quiet stretches, and one long hold-off.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ask) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_ask = 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  always @(posedge clk) begin
    report_t owed;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        owed = xmodem_rx_step(cur_item);
        if (cur_fixed) owed = cur_want;
        status_due.push_back(owed);
      end
      if (out_tvalid && out_tready) begin
        if (status_due.size() == 0) begin
          $display("%0t ns: result %06h with nothing outstanding", $time, out_tdata);
          mismatches++;
        end else begin
          owed = status_due.pop_front();
          if (out_tdata[3:0] !== owed.status) begin
            $display("%0t ns: status expected %0d (%s), actual %0d", $time,
                     owed.status, owed.status.name(), out_tdata[3:0]);
            mismatches++;
          end
          if (out_tdata[11:4] !== owed.read_data) begin
            $display("%0t ns: read_data expected %02h, actual %02h", $time,
                     owed.read_data, out_tdata[11:4]);
            mismatches++;
          end
          if (out_tdata[19:12] !== owed.last_good) begin
            $display("%0t ns: last_good_block expected %02h, actual %02h", $time,
                     owed.last_good, out_tdata[19:12]);
            mismatches++;
          end
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    row_t      plan [$];
    xfer_t     it;
    pkt_kind_t kind;
    int        base;
    int        pick;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    clear_rx_model();

    plan = '{
      '{1'b1, 8'h00,   7'd0,   1, 1'b1, xmb_pkg::ST_READBACK,   8'h00, 8'h00},
      '{1'b1, 8'hFF, 7'd127,   1, 1'b1, xmb_pkg::ST_READBACK,   8'h00, 8'h00},
      '{1'b0, 8'h00, 7'd127,   1, 1'b1, xmb_pkg::ST_IGNORED,    8'h00, 8'h00},
      '{1'b0, 8'hFF,   7'd0,   1, 1'b1, xmb_pkg::ST_IGNORED,    8'h00, 8'h00},
      '{1'b0, xmb_pkg::CH_EOT, 7'd0, 1, 1'b1, xmb_pkg::ST_EOT,  8'h00, 8'h00},
      '{1'b0, xmb_pkg::CH_CAN, 7'd0, 1, 1'b1, xmb_pkg::ST_CANCEL, 8'h00, 8'h00},
      // Block zero repeats the last good block, so the packet is dropped.
      '{1'b0, xmb_pkg::CH_SOH, 7'd0, 1, 1'b1, xmb_pkg::ST_SOH,  8'h00, 8'h00},
      '{1'b0, 8'h00,   7'd0,   1, 1'b1, xmb_pkg::ST_DUP,        8'h00, 8'h00},
      '{1'b0, 8'hFF,   7'd0,   1, 1'b1, xmb_pkg::ST_DISCARD,    8'h00, 8'h00},
      '{1'b0, 8'hAA,   7'd0, 128, 1'b0, xmb_pkg::ST_DISCARD,    8'h00, 8'h00},
      '{1'b0, 8'h00,   7'd0,   1, 1'b1, xmb_pkg::ST_DISCARD,    8'h00, 8'h00},
      // A good block one, whose first payload byte looks like an EOT.
      '{1'b0, xmb_pkg::CH_SOH, 7'd0, 1, 1'b1, xmb_pkg::ST_SOH,  8'h00, 8'h00},
      '{1'b0, 8'h01,   7'd0,   1, 1'b1, xmb_pkg::ST_BLOCK_OK,   8'h00, 8'h00},
      '{1'b0, 8'hFE,   7'd0,   1, 1'b1, xmb_pkg::ST_COMPL_OK,   8'h00, 8'h00},
      '{1'b0, xmb_pkg::CH_EOT, 7'd0, 1, 1'b1, xmb_pkg::ST_DATA, 8'h00, 8'h00},
      '{1'b0, 8'hFF,   7'd0, 126, 1'b0, xmb_pkg::ST_DATA,       8'h00, 8'h00},
      '{1'b0, 8'h00,   7'd0,   1, 1'b1, xmb_pkg::ST_DATA_DONE,  8'h00, 8'h00},
      '{1'b0, 8'h86,   7'd0,   1, 1'b0, xmb_pkg::ST_BLOCK_DONE, 8'h00, 8'h00},
      '{1'b1, 8'h00,   7'd0,   1, 1'b1, xmb_pkg::ST_READBACK,   8'h04, 8'h01},
      '{1'b1, 8'h00, 7'd127,   1, 1'b1, xmb_pkg::ST_READBACK,   8'h00, 8'h01},
      // Block two with a checksum that cannot match.
      '{1'b0, xmb_pkg::CH_SOH, 7'd0, 1, 1'b0, xmb_pkg::ST_SOH,  8'h00, 8'h00},
      '{1'b0, 8'h02,   7'd0,   1, 1'b0, xmb_pkg::ST_BLOCK_OK,   8'h00, 8'h00},
      '{1'b0, 8'hFD,   7'd0,   1, 1'b0, xmb_pkg::ST_COMPL_OK,   8'h00, 8'h00},
      '{1'b0, 8'h80,   7'd0, 128, 1'b0, xmb_pkg::ST_DATA,       8'h00, 8'h00},
      '{1'b0, 8'hFF,   7'd0,   1, 1'b1, xmb_pkg::ST_CHK_FAIL,   8'h00, 8'h01},
      // Out-of-sequence block, then a cancel in the middle of the packet.
      '{1'b0, xmb_pkg::CH_SOH, 7'd0, 1, 1'b0, xmb_pkg::ST_SOH,  8'h00, 8'h00},
      '{1'b0, 8'h07,   7'd0,   1, 1'b1, xmb_pkg::ST_WRONG,      8'h00, 8'h01},
      '{1'b0, xmb_pkg::CH_CAN, 7'd0, 1, 1'b1, xmb_pkg::ST_CANCEL, 8'h00, 8'h00},
      // Bad complement, then a cancel during the payload.
      '{1'b0, xmb_pkg::CH_SOH, 7'd0, 1, 1'b0, xmb_pkg::ST_SOH,  8'h00, 8'h00},
      '{1'b0, 8'h01,   7'd0,   1, 1'b1, xmb_pkg::ST_BLOCK_OK,   8'h00, 8'h00},
      '{1'b0, 8'h00,   7'd0,   1, 1'b1, xmb_pkg::ST_WRONG,      8'h00, 8'h00},
      '{1'b0, xmb_pkg::CH_CAN, 7'd0, 1, 1'b1, xmb_pkg::ST_CANCEL, 8'h00, 8'h00},
      '{1'b1, 8'h00,   7'd0,   1, 1'b1, xmb_pkg::ST_READBACK,   8'h00, 8'h00}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      repeat (plan[k].reps) begin
        it = '{plan[k].readback, plan[k].rx, plan[k].idx};
        send_item(it, plan[k].fixed, '{plan[k].st, plan[k].rd, plan[k].lgb});
      end
    end

    // The result side is held off at the start while packets keep coming.
    // The opening stretch of the random part runs with no random stalls on either side.
    base     = items_sent;
    hold_ask = 1'b1;
    while (items_sent < base + RAND_ITEMS) begin
      calm = (items_sent - base < CALM_ITEMS);
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        if (pick < 40)      kind = PK_GOOD;
        else if (pick < 50) kind = PK_REPEAT;
        else if (pick < 58) kind = PK_OUT_OF_SEQ;
        else if (pick < 66) kind = PK_BAD_COMPL;
        else if (pick < 74) kind = PK_BAD_SUM;
        else                kind = PK_ABORT;
        send_packet(kind);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0:       send_readback(7'($urandom_range(0, 127)));
            1:       send_serial(xmb_pkg::CH_EOT);
            default: send_serial(8'($urandom_range(0, 255)));
          endcase
        end
      end
      // Noise or a cancelled block number can leave the framing mid-packet.
      if (fr_phase != SEEK_SOH) send_serial(xmb_pkg::CH_CAN);
    end
    calm = 1'b0;

    in_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
design/xmb_pkg.sv
design/xmb_payload_ram.sv
design/xmb_ctrl.sv
design/xmodem_block_receiver.sv
verif/tb.sv
